// File: design/erc_pkg.sv
// ----------------------------------------------------------------------------
// erc_pkg: shared types and the rate table for the envelope rate counter
// Holds the counter widths, the counter select code and the lookup that maps
// a 5-bit rate onto one counter and a shift.
// ----------------------------------------------------------------------------
package erc_pkg;

   localparam int FAST_W      = 11;
   localparam int THIRD_W     = 9;
   localparam int FIFTH_W     = 8;
   localparam int THIRD_PH_W  = 2;
   localparam int FIFTH_PH_W  = 3;
   localparam int RATE_W      = 5;
   localparam int SHIFT_W     = 4;

   // Phase reload values: the phase counts down from these after a step.
   localparam logic [THIRD_PH_W-1:0] THIRD_PH_RELOAD = THIRD_PH_W'(2);
   localparam logic [FIFTH_PH_W-1:0] FIFTH_PH_RELOAD = FIFTH_PH_W'(4);

   typedef enum logic [1:0] {
      SEL_FIFTH = 2'd0,
      SEL_FAST  = 2'd1,
      SEL_THIRD = 2'd2
   } sel_type;

   typedef struct packed {
      sel_type              sel;
      logic [SHIFT_W-1:0]   shift;
   } rate_entry_type;

   // Rate table: each rate picks one counter and how many low bits must be clear.
   function automatic rate_entry_type rate_lookup(input logic [RATE_W-1:0] rate);
      rate_entry_type e;
      e.sel   = SEL_FAST;
      e.shift = '0;
      unique case (rate)
         5'd0:  begin e.sel = SEL_FAST;  e.shift = 4'd0;  end
         5'd1:  begin e.sel = SEL_FAST;  e.shift = 4'd11; end
         5'd2:  begin e.sel = SEL_THIRD; e.shift = 4'd9;  end
         5'd3:  begin e.sel = SEL_FIFTH; e.shift = 4'd8;  end
         5'd4:  begin e.sel = SEL_FAST;  e.shift = 4'd10; end
         5'd5:  begin e.sel = SEL_THIRD; e.shift = 4'd8;  end
         5'd6:  begin e.sel = SEL_FIFTH; e.shift = 4'd7;  end
         5'd7:  begin e.sel = SEL_FAST;  e.shift = 4'd9;  end
         5'd8:  begin e.sel = SEL_THIRD; e.shift = 4'd7;  end
         5'd9:  begin e.sel = SEL_FIFTH; e.shift = 4'd6;  end
         5'd10: begin e.sel = SEL_FAST;  e.shift = 4'd8;  end
         5'd11: begin e.sel = SEL_THIRD; e.shift = 4'd6;  end
         5'd12: begin e.sel = SEL_FIFTH; e.shift = 4'd5;  end
         5'd13: begin e.sel = SEL_FAST;  e.shift = 4'd7;  end
         5'd14: begin e.sel = SEL_THIRD; e.shift = 4'd5;  end
         5'd15: begin e.sel = SEL_FIFTH; e.shift = 4'd4;  end
         5'd16: begin e.sel = SEL_FAST;  e.shift = 4'd6;  end
         5'd17: begin e.sel = SEL_THIRD; e.shift = 4'd4;  end
         5'd18: begin e.sel = SEL_FIFTH; e.shift = 4'd3;  end
         5'd19: begin e.sel = SEL_FAST;  e.shift = 4'd5;  end
         5'd20: begin e.sel = SEL_THIRD; e.shift = 4'd3;  end
         5'd21: begin e.sel = SEL_FIFTH; e.shift = 4'd2;  end
         5'd22: begin e.sel = SEL_FAST;  e.shift = 4'd4;  end
         5'd23: begin e.sel = SEL_THIRD; e.shift = 4'd2;  end
         5'd24: begin e.sel = SEL_FIFTH; e.shift = 4'd1;  end
         5'd25: begin e.sel = SEL_FAST;  e.shift = 4'd3;  end
         5'd26: begin e.sel = SEL_THIRD; e.shift = 4'd1;  end
         5'd27: begin e.sel = SEL_FIFTH; e.shift = 4'd0;  end
         5'd28: begin e.sel = SEL_FAST;  e.shift = 4'd2;  end
         5'd29: begin e.sel = SEL_THIRD; e.shift = 4'd0;  end
         5'd30: begin e.sel = SEL_FAST;  e.shift = 4'd1;  end
         default: begin e.sel = SEL_FAST; e.shift = 4'd0; end
      endcase
      return e;
   endfunction

   // Low-bit test on an 11-bit value: true when bits below shift are all zero.
   function automatic logic low_bits_clear(input logic [FAST_W-1:0] v,
                                           input logic [SHIFT_W-1:0] shift);
      logic clear;
      clear = 1'b1;
      for (int i = 0; i < FAST_W; i++) begin
         if ((SHIFT_W'(i) < shift) && v[i]) begin
            clear = 1'b0;
         end
      end
      return clear;
   endfunction

endpackage

// File: design/erc_counters.sv
// ----------------------------------------------------------------------------
// erc_counters: envelope timing counters and poll evaluation
// Keeps the fast, divide-by-three and divide-by-five down-counters with their
// phases, advances them on a tick and answers a poll from the current state.
// ----------------------------------------------------------------------------
module erc_counters (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tick,
   input  logic [erc_pkg::RATE_W-1:0] rate,
   output logic                       fire
);
   import erc_pkg::*;

   logic [FAST_W-1:0]     fast_count_ff,  fast_count_in;
   logic [THIRD_W-1:0]    third_count_ff, third_count_in;
   logic [THIRD_PH_W-1:0] third_phase_ff, third_phase_in;
   logic [FIFTH_W-1:0]    fifth_count_ff, fifth_count_in;
   logic [FIFTH_PH_W-1:0] fifth_phase_ff, fifth_phase_in;
   rate_entry_type        entry;

   // Next counter values for one tick; the slow counters step when their phase is zero.
   always_comb begin
      fast_count_in  = fast_count_ff;
      third_count_in = third_count_ff;
      third_phase_in = third_phase_ff;
      fifth_count_in = fifth_count_ff;
      fifth_phase_in = fifth_phase_ff;
      if (tick) begin
         fast_count_in = fast_count_ff - FAST_W'(1);
         if (third_phase_ff == '0) begin
            third_phase_in = THIRD_PH_RELOAD;
            third_count_in = third_count_ff - THIRD_W'(1);
         end else begin
            third_phase_in = third_phase_ff - THIRD_PH_W'(1);
         end
         if (fifth_phase_ff == '0) begin
            fifth_phase_in = FIFTH_PH_RELOAD;
            fifth_count_in = fifth_count_ff - FIFTH_W'(1);
         end else begin
            fifth_phase_in = fifth_phase_ff - FIFTH_PH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_count_ff  <= '0;
         third_count_ff <= '0;
         third_phase_ff <= '0;
         fifth_count_ff <= '0;
         fifth_phase_ff <= '0;
      end else begin
         fast_count_ff  <= fast_count_in;
         third_count_ff <= third_count_in;
         third_phase_ff <= third_phase_in;
         fifth_count_ff <= fifth_count_in;
         fifth_phase_ff <= fifth_phase_in;
      end
   end

   // Poll answer: select the counter named by the rate and test its low bits.
   always_comb begin
      entry = rate_lookup(rate);
      case (entry.sel)
         SEL_FIFTH: fire = (fifth_phase_ff == '0) &&
                           low_bits_clear(FAST_W'(fifth_count_ff), entry.shift);
         SEL_THIRD: fire = (third_phase_ff == '0) &&
                           low_bits_clear(FAST_W'(third_count_ff), entry.shift);
         default:   fire = low_bits_clear(fast_count_ff, entry.shift);
      endcase
      if (rate == '0) begin
         fire = 1'b0;
      end
   end

endmodule

// File: design/envelope_rate_counter.sv
// ----------------------------------------------------------------------------
// envelope_rate_counter: envelope event timing from three down-counters
// Ticks advance the counters; polls report whether a rate fires now.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries items of req_action and req_rate. An action of
//   zero is a tick: it advances the counters and yields no result. An action
//   of one is a poll: it yields one rsp_fire transfer on the rsp_ channel.
//   Rate zero never fires.
//   One item is taken per clock cycle while req_ready is high. A poll's answer
//   is worked out from the counter state in the cycle it is accepted and is
//   shown on rsp_ from the result register; the rate lookup and the low-bit
//   test sit between the counter registers and the result register.
//   When the receiver stalls, the result register holds its answer and a
//   second answer goes into a one-entry skid register, so req_ready drops
//   only once both are full. Ticks and polls keep their order with respect
//   to the counters, since state changes at the tick's acceptance.
//   Reset clears all counters and phases to zero and empties both result
//   registers.
// ----------------------------------------------------------------------------
module envelope_rate_counter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_action,
   input  logic [erc_pkg::RATE_W-1:0] req_rate,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_fire
);
   import erc_pkg::*;

   logic req_take;
   logic poll_take;
   logic tick_take;
   logic fire_now;
   logic out_valid_ff,  out_valid_in;
   logic out_fire_ff,   out_fire_in;
   logic skid_valid_ff, skid_valid_in;
   logic skid_fire_ff,  skid_fire_in;

   // Input transfer decode.
   assign req_ready = !skid_valid_ff;
   assign req_take  = req_valid && req_ready;
   assign poll_take = req_take && req_action;
   assign tick_take = req_take && !req_action;

   erc_counters u_counters (
      .clock (clock),
      .reset (reset),
      .tick  (tick_take),
      .rate  (req_rate),
      .fire  (fire_now)
   );

   // Result register with skid entry behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_fire_in   = out_fire_ff;
      skid_valid_in = skid_valid_ff;
      skid_fire_in  = skid_fire_ff;
      if (out_valid_ff && !rsp_ready) begin
         if (poll_take) begin
            skid_valid_in = 1'b1;
            skid_fire_in  = fire_now;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_fire_in   = skid_fire_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = poll_take;
         out_fire_in  = fire_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_fire_ff  <= out_fire_in;
      skid_fire_ff <= skid_fire_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_fire  = out_fire_ff;

endmodule

// File: design/erc_checker.sv
// ----------------------------------------------------------------------------
// erc_checker: port-level checks for the envelope rate counter
// Watches the top-level ports and flags result timing slips.
// ----------------------------------------------------------------------------
module erc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_action,
   input logic [erc_pkg::RATE_W-1:0] req_rate,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_fire
);
   import erc_pkg::*;

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A stalled result holds its value.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fire))
      else $error("stalled result changed");

   // A tick transfer into an empty output produces no result.
   a_tick_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_action && !rsp_valid |=> !rsp_valid)
      else $error("tick produced a result");

   // A rate-zero poll into an empty output answers no fire on the next cycle.
   a_rate_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action && (req_rate == '0) && !rsp_valid
      |=> rsp_valid && !rsp_fire)
      else $error("rate zero poll fired or was lost");

endmodule

bind envelope_rate_counter erc_checker u_erc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_action (req_action),
   .req_rate   (req_rate),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_fire   (rsp_fire)
);
